// ===== rtl/core/pli_pkg.sv =====
package pli_pkg;

	localparam int CMD_W          = 2;
	localparam int DIST_W         = 24;
	localparam int VALUE_W        = 24;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int PROD_W         = DIST_W + VALUE_W;
	localparam int SUM_W          = PROD_W + 2;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} pli_command_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_FEW_POINTS = 3'd1,
		STS_ZERO_WIDTH = 3'd2,
		STS_FULL       = 3'd3,
		STS_SATURATED  = 3'd4
	} pli_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic [DIST_W-1:0]         point_distance;
		logic signed [VALUE_W-1:0] point_value;
		logic [DIST_W-1:0]         query_distance;
	} pli_req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		pli_status_t               status;
	} pli_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_READ_M,
		S_READ_M1,
		S_LATCH,
		S_MUL,
		S_DIV_START,
		S_DIV,
		S_DONE
	} pli_state_t;

	typedef enum logic [2:0] {
		ADDR_ZERO,
		ADDR_LAST,
		ADDR_SCAN,
		ADDR_M,
		ADDR_M1,
		ADDR_COUNT
	} pli_addr_sel_t;

	typedef enum logic [1:0] {
		M_ZERO,
		M_LAST,
		M_CHK_PREV,
		M_CHK
	} pli_m_sel_t;

	typedef enum logic [1:0] {
		RES_CODE,
		RES_FLAT,
		RES_INTERP
	} pli_res_kind_t;

	typedef struct packed {
		logic          capture;
		pli_addr_sel_t addr_sel;
		logic          wr_en;
		logic          cnt_clear;
		logic          cnt_inc;
		logic          scan_start;
		logic          scan_step;
		logic          m_load;
		pli_m_sel_t    m_sel;
		logic          lat1;
		logic          lat2;
		logic          mul;
		logic          div_start;
		logic          res_load;
		pli_res_kind_t res_kind;
		pli_status_t   res_code;
		logic          out_load;
	} pli_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             full;
		logic             few;
		logic             two;
		logic             le_first;
		logic             ge_last;
		logic             chk_valid;
		logic             chk_gt;
		logic             chk_end;
		logic             flat;
		logic             div_done;
	} pli_stat_t;

endpackage

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolation table. Breakpoints (distance, value) are loaded
// with clear and append transactions in ascending distance order; a query
// transaction returns E1 + (E2-E1)*(d-d1)/(d2-d1) along the chosen segment
// (first segment below the table, last segment at or past its end), truncated
// toward zero and saturated, with a status code. Transactions are handled one at
// a time. Clear, append and unused commands go from decode straight to the
// result. A query over a table of two or more points scans the distance memory
// one entry per cycle up to the chosen segment, and the quotient comes from a
// one-bit-per-cycle divider of 48 steps. The next transaction may be accepted
// while a result still waits in the output register.
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pli_pkg::pli_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pli_pkg::pli_rsp_t rsp
);

	import pli_pkg::*;

	pli_cmd_t  ctrl_cmd;
	pli_stat_t dp_stat;

	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	pli_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (ctrl_cmd),
		.stat   (dp_stat),
		.rsp    (rsp)
	);

	// a finished result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.out_load |-> (!rsp_valid || rsp_ready))
		else $error("result register overwritten while pending");

	// one transaction in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second transaction accepted while busy");

	// appends never write past the end of the table
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.wr_en |-> !dp_stat.full)
		else $error("breakpoint written into a full table");

	// the divider only starts on a segment of nonzero width
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.div_start |-> !dp_stat.flat)
		else $error("divide started on a zero-width segment");

endmodule

// ===== rtl/core/pli_ram.sv =====
module pli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/pli_div.sv =====
module pli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pli_pkg::PROD_W-1:0] dividend,
	input  logic [pli_pkg::DIST_W-1:0] divisor,
	output logic                       done,
	output logic [pli_pkg::PROD_W-1:0] quotient
);

	import pli_pkg::*;

	localparam int STEP_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quo_q;
	logic [DIST_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIST_W:0]   trial;
	logic [DIST_W:0]   diff;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PROD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/pli_dp.sv =====
module pli_dp #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pli_pkg::pli_req_t req,
	input  pli_pkg::pli_cmd_t cmd,
	output pli_pkg::pli_stat_t stat,
	output pli_pkg::pli_rsp_t rsp
);

	import pli_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	pli_req_t                 req_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         cnt_m1;
	logic [CNT_W-1:0]         cnt_m2;
	logic [IDX_W-1:0]         scan_idx_q;
	logic [IDX_W-1:0]         chk_idx_s1;
	logic                     chk_valid_s1;
	logic [IDX_W-1:0]         m_q;
	logic [IDX_W-1:0]         addr;
	logic [DIST_W-1:0]        rd_dist;
	logic [VALUE_W-1:0]       rd_val;
	logic [DIST_W-1:0]        d1_q;
	logic [VALUE_W-1:0]       e1_q;
	logic signed [DIST_W:0]   dw_diff;
	logic signed [DIST_W:0]   dd_diff;
	logic signed [VALUE_W:0]  de_diff;
	logic [DIST_W-1:0]        mag_dw;
	logic [DIST_W-1:0]        mag_dd;
	logic [VALUE_W-1:0]       mag_de;
	logic [DIST_W-1:0]        mag_dw_q;
	logic [DIST_W-1:0]        mag_dd_q;
	logic [VALUE_W-1:0]       mag_de_q;
	logic                     neg_q;
	logic                     flat_q;
	logic [PROD_W-1:0]        prod_q;
	logic [PROD_W-1:0]        quo;
	logic                     div_done;
	logic signed [SUM_W-1:0]  e1_ext;
	logic signed [SUM_W-1:0]  q_ext;
	logic signed [SUM_W-1:0]  sum_r;
	logic signed [VALUE_W-1:0] sat_val;
	pli_status_t              sat_sts;
	pli_rsp_t                 res_q;
	pli_rsp_t                 out_q;

	assign cnt_m1 = count_q - CNT_W'(1);
	assign cnt_m2 = count_q - CNT_W'(2);

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_ZERO:  addr = '0;
			ADDR_LAST:  addr = cnt_m1[IDX_W-1:0];
			ADDR_SCAN:  addr = scan_idx_q;
			ADDR_M:     addr = m_q;
			ADDR_M1:    addr = m_q + IDX_W'(1);
			ADDR_COUNT: addr = count_q[IDX_W-1:0];
			default:    addr = '0;
		endcase
	end

	pli_ram #(
		.WIDTH (DIST_W),
		.DEPTH (MAX_POINTS)
	) u_dist_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (addr),
		.wr_data (req_q.point_distance),
		.rd_addr (addr),
		.rd_data (rd_dist)
	);

	pli_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_POINTS)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (addr),
		.wr_data (req_q.point_value),
		.rd_addr (addr),
		.rd_data (rd_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			chk_valid_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_clear) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.scan_start) begin
				chk_valid_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				chk_valid_s1 <= 1'b1;
			end
		end
	end

	// segment arithmetic on the breakpoints just read
	assign dw_diff = $signed({1'b0, rd_dist}) - $signed({1'b0, d1_q});
	assign dd_diff = $signed({1'b0, req_q.query_distance}) - $signed({1'b0, d1_q});
	assign de_diff = $signed({rd_val[VALUE_W-1], rd_val}) - $signed({e1_q[VALUE_W-1], e1_q});
	assign mag_dw  = dw_diff[DIST_W] ? DIST_W'(-dw_diff) : DIST_W'(dw_diff);
	assign mag_dd  = dd_diff[DIST_W] ? DIST_W'(-dd_diff) : DIST_W'(dd_diff);
	assign mag_de  = de_diff[VALUE_W] ? VALUE_W'(-de_diff) : VALUE_W'(de_diff);

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (mag_dw_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign e1_ext = SUM_W'($signed(e1_q));
	assign q_ext  = $signed({2'b00, quo});
	assign sum_r  = neg_q ? e1_ext - q_ext : e1_ext + q_ext;

	always_comb begin
		priority if (sum_r > SUM_W'(VALUE_MAX)) begin
			sat_val = VALUE_MAX;
			sat_sts = STS_SATURATED;
		end else if (sum_r < SUM_W'(VALUE_MIN)) begin
			sat_val = VALUE_MIN;
			sat_sts = STS_SATURATED;
		end else begin
			sat_val = sum_r[VALUE_W-1:0];
			sat_sts = STS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= IDX_W'(1);
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			chk_idx_s1 <= scan_idx_q;
		end
		if (cmd.m_load) begin
			unique case (cmd.m_sel)
				M_ZERO:     m_q <= '0;
				M_LAST:     m_q <= cnt_m2[IDX_W-1:0];
				M_CHK_PREV: m_q <= chk_idx_s1 - IDX_W'(1);
				M_CHK:      m_q <= chk_idx_s1;
				default:    m_q <= '0;
			endcase
		end
		if (cmd.lat1) begin
			d1_q <= rd_dist;
			e1_q <= rd_val;
		end
		if (cmd.lat2) begin
			mag_dw_q <= mag_dw;
			mag_dd_q <= mag_dd;
			mag_de_q <= mag_de;
			neg_q    <= de_diff[VALUE_W] ^ dd_diff[DIST_W] ^ dw_diff[DIST_W];
			flat_q   <= dw_diff == '0;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(mag_de_q) * PROD_W'(mag_dd_q);
		end
		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_CODE: begin
					res_q.result_value <= '0;
					res_q.status       <= cmd.res_code;
				end
				RES_FLAT: begin
					res_q.result_value <= e1_q;
					res_q.status       <= STS_ZERO_WIDTH;
				end
				RES_INTERP: begin
					res_q.result_value <= sat_val;
					res_q.status       <= sat_sts;
				end
				default: begin
					res_q.result_value <= '0;
					res_q.status       <= STS_OK;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign stat.command   = req_q.command;
	assign stat.full      = count_q == CNT_W'(MAX_POINTS);
	assign stat.few       = count_q < CNT_W'(2);
	assign stat.two       = count_q == CNT_W'(2);
	assign stat.le_first  = req_q.query_distance <= rd_dist;
	assign stat.ge_last   = req_q.query_distance >= rd_dist;
	assign stat.chk_valid = chk_valid_s1;
	assign stat.chk_gt    = rd_dist > req_q.query_distance;
	assign stat.chk_end   = chk_idx_s1 == cnt_m2[IDX_W-1:0];
	assign stat.flat      = flat_q;
	assign stat.div_done  = div_done;

	assign rsp = out_q;

endmodule

// ===== rtl/core/pli_ctrl.sv =====
module pli_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  pli_pkg::pli_stat_t stat,
	output pli_pkg::pli_cmd_t  cmd
);

	import pli_pkg::*;

	pli_state_t state_q;
	pli_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				// read entry 0 early in case this is a query
				cmd.addr_sel = ADDR_ZERO;
				cmd.res_kind = RES_CODE;
				cmd.res_code = STS_OK;
				unique case (stat.command)
					CMD_CLEAR: begin
						cmd.cnt_clear = 1'b1;
						cmd.res_load  = 1'b1;
						state_d       = S_DONE;
					end
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.res_code = STS_FULL;
						end else begin
							cmd.addr_sel = ADDR_COUNT;
							cmd.wr_en    = 1'b1;
							cmd.cnt_inc  = 1'b1;
						end
						cmd.res_load = 1'b1;
						state_d      = S_DONE;
					end
					CMD_QUERY: begin
						if (stat.few) begin
							cmd.res_code = STS_FEW_POINTS;
							cmd.res_load = 1'b1;
							state_d      = S_DONE;
						end else begin
							state_d = S_FIRST;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_FIRST: begin
				cmd.addr_sel = ADDR_LAST;
				if (stat.le_first) begin
					cmd.m_load = 1'b1;
					cmd.m_sel  = M_ZERO;
					state_d    = S_READ_M;
				end else begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				if (stat.ge_last) begin
					cmd.m_load = 1'b1;
					cmd.m_sel  = M_LAST;
					state_d    = S_READ_M;
				end else if (stat.two) begin
					cmd.m_load = 1'b1;
					cmd.m_sel  = M_ZERO;
					state_d    = S_READ_M;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.addr_sel = ADDR_SCAN;
				// stop at the first breakpoint beyond the query, or at the second-to-last one
				if (stat.chk_valid && stat.chk_gt) begin
					cmd.m_load = 1'b1;
					cmd.m_sel  = M_CHK_PREV;
					state_d    = S_READ_M;
				end else if (stat.chk_valid && stat.chk_end) begin
					cmd.m_load = 1'b1;
					cmd.m_sel  = M_CHK;
					state_d    = S_READ_M;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_READ_M: begin
				cmd.addr_sel = ADDR_M;
				state_d      = S_READ_M1;
			end
			S_READ_M1: begin
				cmd.addr_sel = ADDR_M1;
				cmd.lat1     = 1'b1;
				state_d      = S_LATCH;
			end
			S_LATCH: begin
				cmd.lat2 = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				if (stat.flat) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FLAT;
					state_d      = S_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_DIV_START;
				end
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_INTERP;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== sim/piecewise_linear_interpolator_tb.sv =====
module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
	localparam int RANDOM_ITEMS = 520;
	localparam int STALL_LIMIT  = 20000;
	localparam int HOLD_OFF     = 400;
	localparam int TAIL_CYCLES  = 64;

	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [DIST_W-1:0] DIST_MAX   = '1;
	localparam longint            VAL_HI     = VALUE_MAX;
	localparam longint            VAL_LO     = VALUE_MIN;

	class breakpoint_scoreboard;
		logic [DIST_W-1:0]         dist_mem [TABLE_DEPTH];
		logic signed [VALUE_W-1:0] value_mem [TABLE_DEPTH];
		int unsigned               npoints;
		pli_rsp_t                  expected_q [$];
		int                        errors;

		function new();
			npoints = 0;
			errors  = 0;
		endfunction

		function longint dist_at(int unsigned idx);
			return longint'({1'b0, dist_mem[idx]});
		endfunction

		function pli_rsp_t interpolate_at(logic [DIST_W-1:0] qd);
			pli_rsp_t    e;
			int unsigned seg;
			int unsigned n;
			longint      d, d1, d2, e1, e2, de, dd, dw, q, r;
			e.result_value = '0;
			e.status       = STS_OK;
			if (npoints < 2) begin
				e.status = STS_FEW_POINTS;
				return e;
			end
			d = longint'({1'b0, qd});
			if (d <= dist_at(0)) begin
				seg = 0;
			end else if (d >= dist_at(npoints - 1)) begin
				seg = npoints - 2;
			end else begin
				// stop at the last breakpoint even if the table is not ascending
				n = 1;
				while (n < npoints - 1 && dist_at(n) <= d)
					n++;
				seg = n - 1;
			end
			d1 = dist_at(seg);
			d2 = dist_at(seg + 1);
			e1 = value_mem[seg];
			e2 = value_mem[seg + 1];
			dw = d2 - d1;
			if (dw == 0) begin
				e.result_value = value_mem[seg];
				e.status       = STS_ZERO_WIDTH;
				return e;
			end
			de = e2 - e1;
			dd = d - d1;
			// divide magnitudes so the quotient truncates toward zero
			q = (de < 0 ? -de : de) * (dd < 0 ? -dd : dd) / (dw < 0 ? -dw : dw);
			if (((de < 0) != (dd < 0)) != (dw < 0))
				r = e1 - q;
			else
				r = e1 + q;
			if (r > VAL_HI) begin
				r        = VAL_HI;
				e.status = STS_SATURATED;
			end else if (r < VAL_LO) begin
				r        = VAL_LO;
				e.status = STS_SATURATED;
			end
			e.result_value = r[VALUE_W-1:0];
			return e;
		endfunction

		function void note_request(pli_req_t item);
			pli_rsp_t e;
			e.result_value = '0;
			e.status       = STS_OK;
			case (item.command)
				CMD_CLEAR: npoints = 0;
				CMD_APPEND: begin
					if (npoints >= TABLE_DEPTH) begin
						e.status = STS_FULL;
					end else begin
						dist_mem[npoints]  = item.point_distance;
						value_mem[npoints] = item.point_value;
						npoints++;
					end
				end
				CMD_QUERY: e = interpolate_at(item.query_distance);
				default: ;
			endcase
			expected_q.push_back(e);
		endfunction

		function void check_result(pli_rsp_t got);
			pli_rsp_t e;
			if (expected_q.size() == 0) begin
				$error("result with none pending: result_value %0d, status %0d",
					got.result_value, got.status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.result_value !== e.result_value) begin
				$error("result_value: expected %0d, got %0d", e.result_value, got.result_value);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	pli_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	pli_rsp_t rsp;

	breakpoint_scoreboard board;
	bit          quiet       = 1'b0;
	int          hold_cycles = 0;
	int unsigned sent_count  = 0;
	int unsigned idle_count  = 0;

	piecewise_linear_interpolator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			board.check_result(rsp);
		if (hold_cycles > 0) begin
			rsp_ready <= 1'b0;
			hold_cycles--;
		end else if (!quiet && $urandom_range(0, 99) < 23) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_count = 0;
		else
			idle_count++;
		if (idle_count >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [DIST_W-1:0] rnd24();
		return DIST_W'($urandom);
	endfunction

	function automatic pli_req_t pack_req(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] pd,
			logic [VALUE_W-1:0] pv, logic [DIST_W-1:0] qd);
		pli_req_t r;
		r.command        = cmd;
		r.point_distance = pd;
		r.point_value    = pv;
		r.query_distance = qd;
		return r;
	endfunction

	task automatic send_item(input pli_req_t item);
		if (!quiet && $urandom_range(0, 99) < 23) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		board.note_request(item);
		sent_count++;
	endtask

	task automatic do_clear();
		send_item(pack_req(CMD_CLEAR, rnd24(), rnd24(), rnd24()));
	endtask

	task automatic do_append(input logic [DIST_W-1:0] pd, input logic signed [VALUE_W-1:0] pv);
		send_item(pack_req(CMD_APPEND, pd, pv, rnd24()));
	endtask

	task automatic do_query(input logic [DIST_W-1:0] qd);
		send_item(pack_req(CMD_QUERY, rnd24(), rnd24(), qd));
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		do_query(24'd0);
		do_append(24'd0, VALUE_MIN);
		do_query(24'd0);
		do_append(DIST_MAX, VALUE_MAX);
		do_query(24'd0);
		do_query(DIST_MAX);
		do_query(24'h800000);
		send_item(pack_req(CMD_UNUSED, rnd24(), rnd24(), rnd24()));
		// two breakpoints at one distance
		do_clear();
		do_append(24'd100, -24'sd77);
		do_append(24'd100, 24'sd5);
		do_query(24'd50);
		// steep segment: extrapolate past both ends into the rails
		do_clear();
		do_append(24'd10, 24'sd0);
		do_append(24'd11, VALUE_MIN);
		do_query(24'd0);
		do_query(DIST_MAX);
		// out-of-order breakpoint gives a segment of negative width
		do_append(24'd5, 24'sd100);
		do_query(24'd12);
		do_query(24'd7);
	endtask

	task automatic run_table_sequence();
		int unsigned               npts;
		int unsigned               nq;
		int unsigned               step_cap;
		int unsigned               vmode;
		int unsigned               i;
		int                        tmp;
		longint                    d;
		logic [DIST_W-1:0]         pts [$];
		logic signed [VALUE_W-1:0] v;
		logic [DIST_W-1:0]         qd;
		do_clear();
		if ($urandom_range(0, 9) == 0)
			npts = 1;
		else if ($urandom_range(0, 19) == 0)
			npts = $urandom_range(2, 200);
		else
			npts = $urandom_range(2, 8);
		case ($urandom_range(0, 2))
			0: step_cap = 3;
			1: step_cap = 65535;
			default: step_cap = 4194303;
		endcase
		vmode = $urandom_range(0, 2);
		d = $urandom_range(0, DIST_MAX) >> $urandom_range(0, 23);
		for (i = 0; i < npts; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				d = $urandom_range(0, DIST_MAX);
			end else if (i > 0) begin
				d = d + $urandom_range(0, step_cap);
				if (d > DIST_MAX)
					d = DIST_MAX;
			end
			case (vmode)
				0: v = VALUE_W'($urandom);
				1: begin
					tmp = int'($urandom_range(0, 2000)) - 1000;
					v = tmp[VALUE_W-1:0];
				end
				default: v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
			endcase
			pts.push_back(d[DIST_W-1:0]);
			do_append(d[DIST_W-1:0], v);
		end
		nq = $urandom_range(1, 6);
		for (i = 0; i < nq; i++) begin
			case ($urandom_range(0, 6))
				0: qd = pts[$urandom_range(0, pts.size() - 1)];
				1: qd = pts[$urandom_range(0, pts.size() - 1)] + 1'b1;
				2: qd = pts[$urandom_range(0, pts.size() - 1)] - 1'b1;
				3: qd = '0;
				4: qd = DIST_MAX;
				default: qd = rnd24();
			endcase
			do_query(qd);
		end
	endtask

	task automatic run_noise();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(1, 4);
		for (i = 0; i < n; i++)
			send_item(pack_req(CMD_W'($urandom_range(0, 3)), rnd24(), rnd24(), rnd24()));
	endtask

	initial begin
		int unsigned start;
		int unsigned done;
		bit          held;
		board     = new();
		held      = 1'b0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		rsp_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_for_drain();

		start = sent_count;
		while (sent_count - start < RANDOM_ITEMS) begin
			done  = sent_count - start;
			quiet = (done >= 200 && done < 300);
			// starve the output so the block backs up onto its input
			if (!held && done >= 100) begin
				held        = 1'b1;
				hold_cycles = HOLD_OFF;
			end
			if ($urandom_range(0, 99) < 80)
				run_table_sequence();
			else
				run_noise();
			if ($urandom_range(0, 19) == 0)
				wait_for_drain();
		end
		quiet = 1'b0;

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
